// ===== design/fdc_pkg.sv =====
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared constants and types for the factoradic digit converter.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int COUNT_W  = 5;  // digit_count, position counter
  localparam int DIGIT_W  = 4;
  localparam int POS_W    = 4;
  localparam int RADIX_W  = 5;  // radix up to 31
  localparam int DIV_STEP = 4;  // quotient bits per divider cycle

  localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd13;

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DIV
  } seq_state_t;

endpackage

// ===== design/fdc_intf.sv =====
// ----------------------------------------------------------------------------
// fdc_intf
// Valid/ready channels: value request, digit result, configuration write.
// ----------------------------------------------------------------------------
interface fdc_req_if #(
  parameter int VALUE_BITS = fdc_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface fdc_res_if;
  logic                        valid;
  logic                        ready;
  logic [fdc_pkg::DIGIT_W-1:0] digit;
  logic [fdc_pkg::POS_W-1:0]   position;
  logic                        last;

  modport source (output valid, output digit, output position, output last, input ready);
  modport sink   (input valid, input digit, input position, input last, output ready);
endinterface

interface fdc_cfg_if;
  logic            valid;
  logic            ready;
  fdc_pkg::count_t digit_count;

  modport source (output valid, output digit_count, input ready);
  modport sink   (input valid, input digit_count, output ready);
endinterface

// ===== design/fdc_div.sv =====
// ----------------------------------------------------------------------------
// fdc_div
// Iterative restoring divider by a small radix, DIV_STEP quotient bits a cycle.
// ----------------------------------------------------------------------------
module fdc_div #(
  parameter int QW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [QW-1:0]               dividend,
  input  logic [fdc_pkg::RADIX_W-1:0] divisor,
  output logic                        busy,
  output logic [QW-1:0]               quotient,
  output logic [fdc_pkg::RADIX_W-1:0] remainder
);

  localparam int STEPS = QW / fdc_pkg::DIV_STEP;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [QW-1:0]               work;
  logic [QW-1:0]               work_next;
  logic [fdc_pkg::RADIX_W-1:0] rem;
  logic [fdc_pkg::RADIX_W-1:0] rem_next;
  logic [fdc_pkg::RADIX_W-1:0] dsr;
  logic [CNT_W-1:0]            cnt;

  // dividend shifts out of the top, quotient bits shift in at the bottom
  always_comb begin
    logic [QW-1:0]               w;
    logic [fdc_pkg::RADIX_W-1:0] r;
    logic [fdc_pkg::RADIX_W:0]   trial;
    w     = work;
    r     = rem;
    trial = '0;
    for (int k = 0; k < fdc_pkg::DIV_STEP; k++) begin
      trial = {r, w[QW-1]};
      w     = {w[QW-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
        w[0]  = 1'b1;
      end
      r = trial[fdc_pkg::RADIX_W-1:0];
    end
    work_next = w;
    rem_next  = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (cnt != '0) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

  assign busy      = (cnt != '0);
  assign quotient  = work;
  assign remainder = rem;

endmodule

// ===== design/factoradic_digit_converter.sv =====
// ----------------------------------------------------------------------------
// factoradic_digit_converter
// Expands an unsigned value into factoradic digits, least significant first.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+-------------------------------------------
//  cfg     | in  | valid/ready  | digit_count (5b), ready always high
//  req     | in  | valid/ready  | value (VALUE_BITS)
//  res     | out | valid/ready  | digit (4b), position (4b), last (1b)
//
//  The shared divider serves every request: each position past zero runs one
//  division of the running quotient by (position+1), four bits a cycle.
//  req is ready only while the sequencer idles.
//  Reset: synchronous; clears the sequencer, the result valid and sets
//  digit_count to 13. No clearing pass.
//  Stalls: the divider works on the next position while a result waits on res.
//
module factoradic_digit_converter #(
  parameter int MAX_DIGITS = fdc_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = fdc_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  fdc_cfg_if.sink   cfg,
  fdc_req_if.sink   req,
  fdc_res_if.source res
);

  // divider width rounded up to whole steps
  localparam int QW = ((VALUE_BITS + fdc_pkg::DIV_STEP - 1) / fdc_pkg::DIV_STEP)
                      * fdc_pkg::DIV_STEP;

  fdc_pkg::seq_state_t state;
  fdc_pkg::seq_state_t state_next;

  fdc_pkg::count_t digit_count;   // config register
  fdc_pkg::count_t n_eff;         // clamped count
  fdc_pkg::count_t n_run;         // count latched for the current request
  fdc_pkg::count_t pos;           // position being emitted
  logic [QW-1:0]   quotient;      // running quotient
  logic [fdc_pkg::DIGIT_W-1:0] cur_digit;

  // result register
  logic                        res_valid;
  logic [fdc_pkg::DIGIT_W-1:0] res_digit;
  logic [fdc_pkg::POS_W-1:0]   res_position;
  logic                        res_last;

  logic slot_free;
  logic is_last;
  logic load_out;
  logic div_start;
  logic req_ready;
  logic req_accept;

  logic                        div_busy;
  logic [QW-1:0]               div_quo;
  logic [fdc_pkg::RADIX_W-1:0] div_rem;

  // --- configuration ---------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= fdc_pkg::DIGIT_COUNT_RESET;
    end else if (cfg.valid) begin
      digit_count <= cfg.digit_count;
    end
  end

  // zero means one, anything above MAX_DIGITS saturates
  always_comb begin
    if (digit_count == '0) begin
      n_eff = fdc_pkg::COUNT_W'(1);
    end else if (digit_count > fdc_pkg::COUNT_W'(MAX_DIGITS)) begin
      n_eff = fdc_pkg::COUNT_W'(MAX_DIGITS);
    end else begin
      n_eff = digit_count;
    end
  end

  // --- sequencer -------------------------------------------------------------
  assign slot_free  = !res_valid || res.ready;
  assign is_last    = ((pos + fdc_pkg::COUNT_W'(1)) == n_run);
  assign req_accept = req.valid && req_ready;

  always_comb begin
    state_next = state;
    case (state)
      fdc_pkg::ST_IDLE: begin
        if (req.valid) state_next = fdc_pkg::ST_EMIT;
      end
      fdc_pkg::ST_EMIT: begin
        if (slot_free) state_next = is_last ? fdc_pkg::ST_IDLE : fdc_pkg::ST_DIV;
      end
      fdc_pkg::ST_DIV: begin
        if (!div_busy) state_next = fdc_pkg::ST_EMIT;
      end
      default: state_next = fdc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    load_out  = 1'b0;
    div_start = 1'b0;
    case (state)
      fdc_pkg::ST_IDLE: req_ready = 1'b1;
      fdc_pkg::ST_EMIT: begin
        load_out  = slot_free;
        div_start = slot_free && !is_last;
      end
      fdc_pkg::ST_DIV: ;
      default: ;
    endcase
  end

  assign req.ready = req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // position 0 has radix one: digit 0, quotient untouched
  always_ff @(posedge clk) begin
    if (req_accept) begin
      quotient  <= QW'(req.value);
      pos       <= '0;
      n_run     <= n_eff;
      cur_digit <= '0;
    end else begin
      if (div_start) pos <= pos + fdc_pkg::COUNT_W'(1);
      if (state == fdc_pkg::ST_DIV && !div_busy) begin
        quotient  <= div_quo;
        cur_digit <= div_rem[fdc_pkg::DIGIT_W-1:0];
      end
    end
  end

  // next position is pos+1, its radix pos+2
  fdc_div #(
    .QW (QW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (quotient),
    .divisor   (pos + fdc_pkg::RADIX_W'(2)),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // --- result register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_digit    <= cur_digit;
      res_position <= pos[fdc_pkg::POS_W-1:0];
      res_last     <= is_last;
    end
  end

  assign res.valid    = res_valid;
  assign res.digit    = res_digit;
  assign res.position = res_position;
  assign res.last     = res_last;

endmodule

// ===== design/fdc_checker.sv =====
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks for the factoradic digit converter, bound to the top.
// ----------------------------------------------------------------------------
module fdc_checker #(
  parameter int MAX_DIGITS = fdc_pkg::MAX_DIGITS_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [fdc_pkg::DIGIT_W-1:0] res_digit,
  input logic [fdc_pkg::POS_W-1:0]   res_position,
  input logic                        res_last
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_digit) && $stable(res_position) && $stable(res_last)))
    else $error("result changed while stalled");

  // one request at a time
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while busy");

  // radix-one position carries zero
  a_pos0: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_position == '0) |-> (res_digit == '0))
    else $error("nonzero digit at position 0");

  // digit stays below its radix
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    ((MAX_DIGITS <= 16) && res_valid) |-> (res_digit <= res_position))
    else $error("digit exceeds position");

endmodule

bind factoradic_digit_converter fdc_checker #(
  .MAX_DIGITS (MAX_DIGITS)
) u_fdc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_digit    (res.digit),
  .res_position (res.position),
  .res_last     (res.last)
);

// ===== tb/fdc_digit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdc_digit_checker
// Watches the cfg, req and res channels, predicts the factoradic digit run of
// every accepted request and compares each accepted result against it.
// ----------------------------------------------------------------------------
module fdc_digit_checker #(
  parameter int MAX_DIGITS = fdc_pkg::MAX_DIGITS_DEF,
  parameter int VALUE_BITS = fdc_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  fdc_cfg_if   cfg,
  fdc_req_if   req,
  fdc_res_if   res,
  output int   mismatches,
  output int   outstanding
);

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [fdc_pkg::DIGIT_W-1:0] digit;
    logic [fdc_pkg::POS_W-1:0]   position;
    logic                        last;
  } digit_rec_t;

  digit_rec_t      pending_digits[$];
  fdc_pkg::count_t digit_count_q;

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Queue the whole digit run for one value at the current digit count.
  // Quotient left above the emitted digits is dropped.
  function automatic void expand_value(input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS-1:0] q;
    logic [VALUE_BITS-1:0] radix;
    logic [VALUE_BITS-1:0] d;
    int                    n;
    digit_rec_t            rec;
    n = int'(digit_count_q);
    if (n < 1) n = 1;                      // zero count still yields one digit
    if (n > MAX_DIGITS) n = MAX_DIGITS;    // saturate
    q = v;
    for (int i = 0; i < n; i++) begin
      d = '0;
      if (i > 0) begin
        radix = VALUE_BITS'(i + 1);
        d     = q % radix;
        q     = q / radix;
      end
      rec.digit    = d[fdc_pkg::DIGIT_W-1:0];
      rec.position = fdc_pkg::POS_W'(i);
      rec.last     = (i + 1 == n);
      pending_digits.insert(pending_digits.size(), rec);
    end
  endfunction

  always @(posedge clk) begin
    digit_rec_t want;
    if (rst) begin
      pending_digits.delete();
      digit_count_q = fdc_pkg::DIGIT_COUNT_RESET;
    end else begin
      if (cfg.valid && cfg.ready)
        digit_count_q = cfg.digit_count;
      if (req.valid && req.ready)
        expand_value(req.value);
      if (res.valid && res.ready) begin
        if (pending_digits.size() == 0) begin
          flag_mismatch($sformatf("unexpected result digit=%0d position=%0d last=%0b",
                                  res.digit, res.position, res.last));
        end else begin
          want = pending_digits.pop_front();
          if (res.digit !== want.digit)
            flag_mismatch($sformatf("digit %0d, wanted %0d at position %0d",
                                    res.digit, want.digit, want.position));
          if (res.position !== want.position)
            flag_mismatch($sformatf("position %0d, wanted %0d",
                                    res.position, want.position));
          if (res.last !== want.last)
            flag_mismatch($sformatf("last %0b, wanted %0b at position %0d",
                                    res.last, want.last, want.position));
        end
      end
    end
    outstanding = pending_digits.size();
  end

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

endmodule

// ===== tb/tb_factoradic_digit_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_factoradic_digit_converter
// Drives value requests and digit_count writes into the converter, stalls the
// result side at random, and reports the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_factoradic_digit_converter;

  localparam int MAX_DIGITS = 16;
  localparam int VALUE_BITS = 32;

  // Hard cycle limit for the whole run of ~310 requests.
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 4;   // idle margin before a cfg write
  localparam int TAIL_CYCLES   = 40;  // quiet time after the last result
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_ITEMS   = 48;
  localparam int MAX_GAP       = 18;

  logic clk;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  bit   steady;      // when set, neither side idles

  fdc_cfg_if                          cfg_ch ();
  fdc_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
  fdc_res_if                          res_ch ();

  factoradic_digit_converter #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch.sink),
    .req (req_ch.sink),
    .res (res_ch.source)
  );

  fdc_digit_checker #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .res         (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("factoradic_digit_converter test failed");
      $finish;
    end
  end

  // Result side: per result, a random stall before ready goes high.
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // valid stays up across back-to-back requests; it drops only for a gap or a drain.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.value <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Hold off requests until every queued digit has come out.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_digit_count(input fdc_pkg::count_t c);
    wait_drained();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.digit_count <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [VALUE_BITS-1:0] factorial(input int k);
    logic [VALUE_BITS-1:0] f;
    f = 1;
    for (int i = 2; i <= k; i++) f = f * VALUE_BITS'(i);
    return f;
  endfunction

  // Mix of wide randoms, small values, all-zero/all-one values, shifted randoms
  // and values around factorial edges, where digit carries change.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5:       v = $urandom_range(0, 255);
      6, 7:       v = factorial($urandom_range(1, 12)) + VALUE_BITS'($urandom_range(0, 2)) - 1;
      8:          v = $urandom_range(0, 1) ? '1 : '0;
      default:    v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  initial begin
    fdc_pkg::count_t c;
    steady             = 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.digit_count <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.value       <= '0;
    rst                <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset count of 13, value extremes and factorial edges.
    send_value('0);
    send_value('1);
    send_value(1);
    send_value(2);
    send_value(5);
    send_value(6);
    send_value(factorial(12) - 1);   // digits 1 to 11 at their maximum
    send_value(factorial(12));       // carries into position 12
    steady = 1'b1;
    send_value(32'hAAAA_AAAA);
    send_value(32'h5555_5555);
    steady = 1'b0;

    write_digit_count(fdc_pkg::count_t'(MAX_DIGITS));
    send_value('1);
    send_value(factorial(12) + 1);
    send_value(0);

    write_digit_count('0);           // zero count behaves as one
    send_value('1);
    send_value(7);

    write_digit_count('1);           // above max saturates
    send_value('1);
    send_value(factorial(11) - 1);

    write_digit_count(fdc_pkg::count_t'(1));
    send_value('1);
    send_value(3);

    write_digit_count(fdc_pkg::count_t'(MAX_DIGITS + 1));
    send_value(32'h8000_0000);
    send_value(24);

    // Random phases, each with its own digit count.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       c = fdc_pkg::count_t'(MAX_DIGITS);
        1:       c = fdc_pkg::count_t'(2);
        default: c = fdc_pkg::count_t'($urandom_range(0, 31));
      endcase
      write_digit_count(c);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 15) == 0)
          steady = ~steady;
        if (k == PHASE_ITEMS / 2)
          wait_drained();            // sender pause with the pipe empty
        send_value(pick_value());
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("factoradic_digit_converter test passed");
    end else begin
      $display("factoradic_digit_converter test failed");
    end
    $finish;
  end

endmodule
